[sv/bitmap_frame_allocator_top_defines.svh]
// Assertion macros for the bitmap frame allocator.
// Depends on nothing; the including module provides clock and reset.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BFA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bfa_pkg.sv]
// Shared types, codes and helpers of the bitmap frame allocator.
// Depends on nothing.
`default_nettype none

package bfa_pkg;

   localparam int ADDR_W  = 24;
   localparam int LEN_W   = 25;
   localparam int CMD_W   = 3;
   localparam int TOTAL_W = 13;
   localparam int WORD_W  = 64;
   localparam int BIT_W   = 6;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
   localparam logic [BIT_W-1:0]   BIT_MAX     = 6'd63;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 3'd0,
      CMD_FREE    = 3'd1,
      CMD_FILL    = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_RESERVE = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic              found;
   } rsp_type;

   // Index of the lowest set bit, by halving the word in BIT_W steps.
   function automatic logic [BIT_W-1:0] find_first_set(input logic [WORD_W-1:0] vec);
      logic [WORD_W-1:0] v;
      logic [BIT_W-1:0]  idx;
      v   = vec;
      idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((v & ((WORD_W'(1) << (1 << k)) - WORD_W'(1))) == '0) begin
            idx[k] = 1'b1;
            v      = v >> (1 << k);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

[sv/bfa_bitmap_ram.sv]
// Word-wide bitmap store: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module bfa_bitmap_ram #(
   parameter int DEPTH  = 64,
   parameter int AW     = 6,
   parameter int DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/bitmap_frame_allocator_top.sv]
// Bitmap frame allocator, first fit: command FSM around a word-wide bitmap RAM.
// Depends on bfa_pkg, bfa_bitmap_ram and bitmap_frame_allocator_top_defines.svh.
//
//   channel   ports                         handshake
//   -------   ---------------------------   -----------------------------------
//   request   start, busy, req_data          beat taken when start && !busy
//   result    rsp_valid, rsp_data            one-cycle strobe, cannot be stalled
//   config    csr_wr_en, csr_wr_data         written on any edge with csr_wr_en
//
// Allocate, free and region commands run a setup step, a first read, then each
// 64-frame word touched in turn, with the read of the next word overlapped with the
// write-back of the last; allocate stops at the first word that holds a free frame.
// Fill-all marks every word used; an unknown command or an empty range skips the store.
// Reset: a clearing pass marks every word used, with busy held high throughout.
// The result strobe follows the last busy cycle; the receiver cannot stall it.
`default_nettype none
`include "bitmap_frame_allocator_top_defines.svh"

module bitmap_frame_allocator_top #(
   parameter int MAX_FRAMES  = 4096,
   parameter int FRAME_BYTES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire bfa_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output bfa_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [bfa_pkg::TOTAL_W-1:0]     csr_wr_data
);

   localparam int ADDR_W      = bfa_pkg::ADDR_W;
   localparam int LEN_W       = bfa_pkg::LEN_W;
   localparam int WORD_W      = bfa_pkg::WORD_W;
   localparam int BIT_W       = bfa_pkg::BIT_W;
   // FRAME_BYTES must be a power of two
   localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
   localparam int NUM_WORDS   = (MAX_FRAMES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int IDX_W       = WADDR_W + BIT_W;
   localparam int AFR_W       = ADDR_W - FRAME_SHIFT;
   localparam int CNT_W       = LEN_W + 1 - FRAME_SHIFT;
   localparam int M1_W        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int M2_W        = (M1_W > AFR_W) ? M1_W : AFR_W;
   localparam int M3_W        = (M2_W > bfa_pkg::TOTAL_W) ? M2_W : bfa_pkg::TOTAL_W;
   localparam int E_W         = M3_W + 1;
   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

   // Configuration register
   logic [bfa_pkg::TOTAL_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= bfa_pkg::TOTAL_RESET;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   // Control and work registers
   bfa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rd_live_ff, rd_live_in;
   logic               pend_ff, pend_in;
   logic [WADDR_W-1:0] fill_w_ff, fill_w_in;
   logic [WADDR_W-1:0] rd_w_ff, rd_w_in;
   logic [WADDR_W-1:0] proc_w_ff, proc_w_in;
   logic               alloc_ff, alloc_in;
   logic               value_ff, value_in;
   logic [E_W-1:0]     first_ff, first_in;
   logic [E_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;

   // Bitmap RAM port
   logic               mem_we;
   logic [WADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [WADDR_W-1:0] mem_raddr;
   logic [WORD_W-1:0]  mem_rdata;

   bfa_bitmap_ram #(
      .DEPTH  (NUM_WORDS),
      .AW     (WADDR_W),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (mem_wdata),
      .rd_en      (mem_re),
      .rd_addr    (mem_raddr),
      .rd_data_ff (mem_rdata)
   );

   // Decode helpers for the accepted beat
   logic [E_W-1:0]    req_frame;
   logic [LEN_W:0]    len_round;
   logic [E_W-1:0]    cnt_floor;
   logic [E_W-1:0]    cnt_ceil;

   assign req_frame = E_W'(req_data.address[ADDR_W-1:FRAME_SHIFT]);
   assign len_round = {1'b0, req_data.length} + (LEN_W + 1)'(FRAME_BYTES - 1);
   assign cnt_floor = E_W'(req_data.length[LEN_W-1:FRAME_SHIFT]);
   assign cnt_ceil  = E_W'(len_round[LEN_W:FRAME_SHIFT]);

   // Range setup: clamp the end of the range to the store
   logic [E_W-1:0] end_sum;
   logic [E_W-1:0] end_m1;
   logic           range_empty;

   assign end_sum     = first_ff + count_ff;
   assign end_m1      = (end_sum > E_W'(MAX_FRAMES)) ? E_W'(MAX_FRAMES - 1)
                                                     : end_sum - E_W'(1);
   assign range_empty = (count_ff == '0) || (first_ff >= E_W'(MAX_FRAMES));

   // Word-level view of the range
   logic [WADDR_W-1:0] lo_word, hi_word;
   logic [BIT_W-1:0]   lo_bit, hi_bit;
   logic [WORD_W-1:0]  word_mask;
   logic [WORD_W-1:0]  free_bits;
   logic [BIT_W-1:0]   free_idx;
   logic [IDX_W-1:0]   hit_frame;
   logic [IDX_W+FRAME_SHIFT-1:0] hit_bytes;

   assign lo_word   = lo_ff[IDX_W-1:BIT_W];
   assign hi_word   = hi_ff[IDX_W-1:BIT_W];
   assign lo_bit    = (proc_w_ff == lo_word) ? lo_ff[BIT_W-1:0] : '0;
   assign hi_bit    = (proc_w_ff == hi_word) ? hi_ff[BIT_W-1:0] : bfa_pkg::BIT_MAX;
   assign word_mask = (ONES << lo_bit) & (ONES >> (bfa_pkg::BIT_MAX - hi_bit));
   assign free_bits = ~mem_rdata & word_mask;
   assign free_idx  = bfa_pkg::find_first_set(free_bits);
   assign hit_frame = {proc_w_ff, free_idx};
   assign hit_bytes = {hit_frame, {FRAME_SHIFT{1'b0}}};

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rd_live_in   = 1'b0;
      pend_in      = 1'b0;
      fill_w_in    = fill_w_ff;
      rd_w_in      = rd_w_ff;
      proc_w_in    = rd_w_ff;
      alloc_in     = alloc_ff;
      value_in     = value_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mem_we       = 1'b0;
      mem_waddr    = proc_w_ff;
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = rd_w_ff;

      unique case (state_ff)
         bfa_pkg::ST_CLEAR, bfa_pkg::ST_FILL: begin
            // Sweep: mark one whole word used per cycle
            mem_we    = 1'b1;
            mem_waddr = fill_w_ff;
            mem_wdata = ONES;
            fill_w_in = fill_w_ff + WADDR_W'(1);
            if (fill_w_ff == WADDR_W'(NUM_WORDS - 1)) begin
               rsp_valid_in = (state_ff == bfa_pkg::ST_FILL);
               state_in     = bfa_pkg::ST_IDLE;
            end
         end
         bfa_pkg::ST_IDLE: begin
            if (start) begin
               alloc_in = 1'b0;
               first_in = req_frame;
               unique case (req_data.command)
                  bfa_pkg::CMD_ALLOC: begin
                     alloc_in = 1'b1;
                     value_in = 1'b1;
                     first_in = '0;
                     count_in = E_W'(total_ff);
                     state_in = bfa_pkg::ST_SETUP;
                  end
                  bfa_pkg::CMD_FREE: begin
                     value_in = 1'b0;
                     count_in = E_W'(1);
                     state_in = bfa_pkg::ST_SETUP;
                  end
                  bfa_pkg::CMD_FILL: begin
                     fill_w_in = '0;
                     state_in  = bfa_pkg::ST_FILL;
                  end
                  bfa_pkg::CMD_RELEASE: begin
                     value_in = 1'b0;
                     count_in = cnt_floor;
                     state_in = bfa_pkg::ST_SETUP;
                  end
                  bfa_pkg::CMD_RESERVE: begin
                     value_in = 1'b1;
                     count_in = cnt_ceil;
                     state_in = bfa_pkg::ST_SETUP;
                  end
                  default: begin
                     state_in = bfa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bfa_pkg::ST_SETUP: begin
            lo_in   = first_ff[IDX_W-1:0];
            hi_in   = end_m1[IDX_W-1:0];
            rd_w_in = first_ff[IDX_W-1:BIT_W];
            if (range_empty) begin
               state_in = bfa_pkg::ST_DONE;
            end else begin
               rd_live_in = 1'b1;
               state_in   = bfa_pkg::ST_SCAN;
            end
         end
         bfa_pkg::ST_SCAN: begin
            // Issue the next read while the previous word is modified
            mem_re     = rd_live_ff;
            pend_in    = rd_live_ff;
            rd_w_in    = rd_w_ff + WADDR_W'(1);
            rd_live_in = rd_live_ff && (rd_w_ff != hi_word);
            if (pend_ff) begin
               if (alloc_ff) begin
                  if (free_bits != '0) begin
                     mem_we                    = 1'b1;
                     mem_wdata                 = mem_rdata | (WORD_W'(1) << free_idx);
                     rsp_data_in.found         = 1'b1;
                     rsp_data_in.frame_address = ADDR_W'(hit_bytes);
                     rsp_valid_in              = 1'b1;
                     state_in                  = bfa_pkg::ST_IDLE;
                  end else if (proc_w_ff == hi_word) begin
                     rsp_valid_in = 1'b1;
                     state_in     = bfa_pkg::ST_IDLE;
                  end
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = value_ff ? (mem_rdata | word_mask) : (mem_rdata & ~word_mask);
                  if (proc_w_ff == hi_word) begin
                     rsp_valid_in = 1'b1;
                     state_in     = bfa_pkg::ST_IDLE;
                  end
               end
               // Drop any read in flight once the command ends
               if (state_in == bfa_pkg::ST_IDLE) begin
                  pend_in    = 1'b0;
                  rd_live_in = 1'b0;
               end
            end
         end
         bfa_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = bfa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         fill_w_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= rd_live_in;
         pend_ff      <= pend_in;
         fill_w_ff    <= fill_w_in;
      end
   end

   // Payload and work registers: no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_w_ff     <= rd_w_in;
      proc_w_ff   <= proc_w_in;
      alloc_ff    <= alloc_in;
      value_ff    <= value_in;
      first_ff    <= first_in;
      count_ff    <= count_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
   end

   assign busy      = (state_ff != bfa_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `BFA_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "result beat while busy")
   `BFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `BFA_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe longer than a cycle")
   `BFA_ASSERT_SAME(a_found_alloc, rsp_valid && rsp_data.found, alloc_ff, "found on non-allocate")

endmodule

`default_nettype wire
